FILE: rtl/core/wvm_pkg.sv
// wvm_pkg: shared types, widths, codes and defaults of the wavetable voice mixer.
// No dependencies; compiled first.
`default_nettype none

package wvm_pkg;

    localparam int VOICES_DEF     = 20;
    localparam int WAVE_DEPTH_DEF = 256;
    localparam int ENV_LEN_DEF    = 500;
    localparam int VIB_LEN_DEF    = 480;
    localparam int VIB_DIV_DEF    = 15;

    localparam int OP_W       = 3;
    localparam int NOTE_W     = 5;
    localparam int ADDR_W     = 9;
    localparam int WAVE_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int LEN_W      = 8;
    localparam int SAMPLE_W   = 21;
    localparam int ETICK_W    = 16;
    localparam int VTICK_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int SAMPLE_MAX = 1048575;
    localparam int SAMPLE_MIN = -1048576;
    localparam int HELD_MAX   = 32767;
    localparam int HELD_MIN   = -32768;

    localparam logic [OP_W-1:0] OP_TICK = 3'd0;
    localparam logic [OP_W-1:0] OP_WAVE = 3'd1;
    localparam logic [OP_W-1:0] OP_ENV  = 3'd2;
    localparam logic [OP_W-1:0] OP_VIB  = 3'd3;
    localparam logic [OP_W-1:0] OP_LEN  = 3'd4;
    localparam logic [OP_W-1:0] OP_REL  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_VIB_EN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RMW,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [LEN_W-1:0]   length;
        logic [LEN_W-1:0]   phase;
        logic               active;
        logic [ADDR_W-1:0]  env_pos;
        logic [ETICK_W-1:0] env_tick;
    } t_voice;

endpackage

`default_nettype wire

FILE: rtl/core/wvm_if.sv
// Item, result and register-write channels of the wavetable voice mixer.
// Depends on wvm_pkg.
`default_nettype none

interface wvm_item_if;
    logic                               valid;
    logic                               ready;
    logic [wvm_pkg::OP_W-1:0]           opcode;
    logic [wvm_pkg::NOTE_W-1:0]         note;
    logic                               pause;
    logic [wvm_pkg::ADDR_W-1:0]         address;
    logic signed [wvm_pkg::WAVE_W-1:0]  wave_value;
    logic [wvm_pkg::GAIN_W-1:0]         gain_value;
    logic [wvm_pkg::LEN_W-1:0]          length_value;

    modport source (output valid, opcode, note, pause, address, wave_value, gain_value,
                    length_value, input ready);
    modport sink (input valid, opcode, note, pause, address, wave_value, gain_value,
                  length_value, output ready);
endinterface

interface wvm_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [wvm_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, sample, input ready);
    modport sink (input valid, sample, output ready);
endinterface

interface wvm_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [wvm_pkg::CFG_IDX_W-1:0]    index;
    logic [wvm_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/wavetable_voice_mixer.sv
// Wavetable voice mixer top level: held note plus release voices, one sample per tick.
// Depends on wvm_pkg, wvm_if (channels) and wvm_voice_mem.
//
//   channel    modport   beat carries
//   i_item     sink      opcode, note, pause, address, wave_value, gain_value, length_value
//   i_cfg      sink      index, data (register write)
//   o_result   source    sample
//
// During a tick the voice state memory is read once per cycle,
// held note first, then every voice, through a read/multiply/accumulate pipe.
// Table writes are direct; set length and start release go through a read-modify-write state.
// Reset is synchronous; voice state clears at once through valid bits, no sweep.
// A finished sample waits in the output register; the next item is still taken,
// and a later tick holds its result only while that register is full.
`default_nettype none

module wavetable_voice_mixer #(
    parameter int VOICES     = wvm_pkg::VOICES_DEF,
    parameter int WAVE_DEPTH = wvm_pkg::WAVE_DEPTH_DEF,
    parameter int ENV_LEN    = wvm_pkg::ENV_LEN_DEF,
    parameter int VIB_LEN    = wvm_pkg::VIB_LEN_DEF,
    parameter int VIB_DIV    = wvm_pkg::VIB_DIV_DEF
) (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    wvm_item_if.sink      i_item,
    wvm_cfg_if.sink       i_cfg,
    wvm_result_if.source  o_result
);

    localparam int VW      = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW      = $clog2(VOICES + 2);
    localparam int WSIZE   = VOICES * WAVE_DEPTH;
    localparam int WA      = $clog2(WSIZE);
    localparam int TBL     = 1 << wvm_pkg::ADDR_W;
    localparam int ACC_RAW = 18 + $clog2(VOICES + 1);
    localparam int ACC_W   = (ACC_RAW > wvm_pkg::SAMPLE_W) ? ACC_RAW : wvm_pkg::SAMPLE_W;
    localparam int PW      = 33;

    // control
    wvm_pkg::t_state r_state, n_state;
    logic            item_acc, item_ready, issue, out_load, run_empty;
    logic            note_ok_in;

    // registers
    logic                           r_vib_en;
    logic [wvm_pkg::ETICK_W-1:0]    r_decay_step;
    logic [wvm_pkg::OP_W-1:0]       r_op;
    logic [wvm_pkg::NOTE_W-1:0]     r_note;
    logic                           r_play;
    logic                           r_note_ok;
    logic [wvm_pkg::LEN_W-1:0]      r_len;
    logic [CW-1:0]                  r_cnt;
    logic                           r_s1_vld, r_s1_held;
    logic [VW-1:0]                  r_s1_voice;
    logic                           r_s2_vld, r_s2_held, r_s2_zero;
    logic                           r_s3_vld, r_s3_held;
    logic signed [wvm_pkg::WAVE_W-1:0] r_s3_w;
    logic signed [PW-1:0]           r_prod;
    logic signed [ACC_W-1:0]        r_acc;
    logic [wvm_pkg::ADDR_W-1:0]     r_vib_pos;
    logic [wvm_pkg::VTICK_W-1:0]    r_vib_tick;
    logic                           r_out_valid;
    logic signed [wvm_pkg::SAMPLE_W-1:0] r_out_sample;

    // memories
    logic signed [wvm_pkg::WAVE_W-1:0] wave_mem [WSIZE];
    logic [wvm_pkg::GAIN_W-1:0]        env_mem  [TBL];
    logic [wvm_pkg::GAIN_W-1:0]        vib_mem  [TBL];
    logic signed [wvm_pkg::WAVE_W-1:0] r_wave_q;
    logic [wvm_pkg::GAIN_W-1:0]        r_env_q;
    logic [wvm_pkg::GAIN_W-1:0]        r_vib_q;

    // voice memory port
    logic            vm_rd_en, vm_wr_en;
    logic [VW-1:0]   vm_rd_addr, vm_wr_addr, slot_voice;
    wvm_pkg::t_voice vm_q, vm_wr_data, s1_next, rmw_data;

    // stage 1
    logic                        s1_act, s1_phase_ok, step_hit, env_end;
    logic [wvm_pkg::LEN_W-1:0]   ph_inc, ph_next;
    logic [wvm_pkg::ETICK_W-1:0] tick_inc;
    logic [wvm_pkg::ADDR_W:0]    pos_inc;
    logic                        wave_rd_en, wave_wr_en, vib_step;
    logic [WA-1:0]               wave_rd_addr, wave_wr_addr;
    logic [wvm_pkg::VTICK_W-1:0] vt_inc, n_vib_tick;
    logic                        vt_hit, vt_end;
    logic [wvm_pkg::ADDR_W:0]    vpos_inc;
    logic [wvm_pkg::ADDR_W-1:0]  n_vib_pos;

    // stage 2 / 3
    logic signed [wvm_pkg::WAVE_W-1:0] s2_w;
    logic [wvm_pkg::GAIN_W-1:0]        s2_g;
    logic signed [PW-1:0]              s2_prod, s3_bias;
    logic signed [PW-15:0]             s3_q;
    logic signed [ACC_W-1:0]           s3_term, acc_sum;
    logic signed [wvm_pkg::SAMPLE_W-1:0] sat_sample;

    assign item_acc   = i_item.valid && item_ready;
    assign note_ok_in = 7'(i_item.note) < 7'(VOICES);
    assign i_item.ready = item_ready;
    assign i_cfg.ready  = 1'b1;
    assign run_empty  = !(r_cnt <= CW'(VOICES)) && !r_s1_vld && !r_s2_vld && !r_s3_vld;

    // ---------------- state machine ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wvm_pkg::ST_IDLE: begin
                if (item_acc) begin
                    if (i_item.opcode == wvm_pkg::OP_TICK) begin
                        n_state = wvm_pkg::ST_RUN;
                    end else if ((i_item.opcode == wvm_pkg::OP_LEN ||
                                  i_item.opcode == wvm_pkg::OP_REL) && note_ok_in) begin
                        n_state = wvm_pkg::ST_RMW;
                    end
                end
            end
            wvm_pkg::ST_RMW: n_state = wvm_pkg::ST_IDLE;
            wvm_pkg::ST_RUN: begin
                if (run_empty) begin
                    n_state = wvm_pkg::ST_DONE;
                end
            end
            wvm_pkg::ST_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    n_state = wvm_pkg::ST_IDLE;
                end
            end
            default: n_state = wvm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        item_ready = 1'b0;
        issue      = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            wvm_pkg::ST_IDLE: item_ready = 1'b1;
            wvm_pkg::ST_RMW:  item_ready = 1'b0;
            wvm_pkg::ST_RUN:  issue = (r_cnt <= CW'(VOICES));
            wvm_pkg::ST_DONE: out_load = !r_out_valid || o_result.ready;
            default:          item_ready = 1'b0;
        endcase
    end

    // ---------------- voice memory access ----------------
    assign slot_voice = (r_cnt == '0) ? VW'(r_note) : VW'(r_cnt - CW'(1));

    always_comb begin
        vm_rd_en   = 1'b0;
        vm_rd_addr = VW'(i_item.note);
        if (issue) begin
            vm_rd_en   = (r_cnt != '0) || r_play;
            vm_rd_addr = slot_voice;
        end else if (item_acc && note_ok_in &&
                     (i_item.opcode == wvm_pkg::OP_LEN || i_item.opcode == wvm_pkg::OP_REL)) begin
            vm_rd_en = 1'b1;
        end
    end

    always_comb begin
        rmw_data = vm_q;
        if (r_op == wvm_pkg::OP_LEN) begin
            rmw_data.length = r_len;
        end else begin
            rmw_data.active   = 1'b1;
            rmw_data.env_pos  = '0;
            rmw_data.env_tick = '0;
        end
    end

    // ---------------- stage 1: voice state update ----------------
    assign s1_act      = r_s1_vld && (r_s1_held ? r_play : vm_q.active);
    assign s1_phase_ok = 9'(vm_q.phase) < 9'(WAVE_DEPTH);
    assign ph_inc      = vm_q.phase + 8'd1;
    assign ph_next     = (ph_inc == vm_q.length) ? '0 : ph_inc;
    assign tick_inc    = vm_q.env_tick + 16'd1;
    assign step_hit    = (tick_inc == r_decay_step);
    assign pos_inc     = {1'b0, vm_q.env_pos} + (step_hit ? 10'd1 : 10'd0);
    assign env_end     = pos_inc >= 10'(ENV_LEN);

    always_comb begin
        s1_next       = vm_q;
        s1_next.phase = ph_next;
        if (!r_s1_held) begin
            s1_next.env_tick = step_hit ? '0 : tick_inc;
            if (env_end) begin
                s1_next.active  = 1'b0;
                s1_next.env_pos = '0;
                s1_next.phase   = '0;
            end else begin
                s1_next.env_pos = pos_inc[wvm_pkg::ADDR_W-1:0];
            end
        end
    end

    assign vm_wr_en   = (r_state == wvm_pkg::ST_RMW) ? r_note_ok : s1_act;
    assign vm_wr_addr = (r_state == wvm_pkg::ST_RMW) ? VW'(r_note) : r_s1_voice;
    assign vm_wr_data = (r_state == wvm_pkg::ST_RMW) ? rmw_data : s1_next;

    wvm_voice_mem #(
        .VOICES (VOICES),
        .VW     (VW)
    ) u_voice_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (vm_rd_en),
        .i_rd_addr (vm_rd_addr),
        .i_wr_en   (vm_wr_en),
        .i_wr_addr (vm_wr_addr),
        .i_wr_data (vm_wr_data),
        .o_rd_data (vm_q)
    );

    assign wave_rd_en   = s1_act && s1_phase_ok;
    assign wave_rd_addr = WA'(r_s1_voice) * WA'(WAVE_DEPTH) + WA'(vm_q.phase);
    assign wave_wr_en   = item_acc && (i_item.opcode == wvm_pkg::OP_WAVE) && note_ok_in &&
                          (i_item.address < 9'(WAVE_DEPTH));
    assign wave_wr_addr = WA'(i_item.note) * WA'(WAVE_DEPTH) + WA'(i_item.address);

    // vibrato tick steps on each held-note sample while vibrato is on; position steps when it reaches VIB_DIV
    assign vib_step  = s1_act && r_s1_held && r_vib_en;
    assign vt_inc    = r_vib_tick + 4'd1;
    assign vt_hit    = (vt_inc == 4'(VIB_DIV));
    assign vpos_inc  = {1'b0, r_vib_pos} + (vt_hit ? 10'd1 : 10'd0);
    assign vt_end    = vpos_inc >= 10'(VIB_LEN);
    assign n_vib_pos  = vt_end ? '0 : vpos_inc[wvm_pkg::ADDR_W-1:0];
    assign n_vib_tick = (vt_hit || vt_end) ? '0 : vt_inc;

    always_ff @(posedge i_clk) begin
        if (wave_wr_en) begin
            wave_mem[wave_wr_addr] <= i_item.wave_value;
        end
        if (wave_rd_en) begin
            r_wave_q <= wave_mem[wave_rd_addr];
        end
        if (item_acc && i_item.opcode == wvm_pkg::OP_ENV) begin
            env_mem[i_item.address] <= i_item.gain_value;
        end
        if (s1_act) begin
            r_env_q <= env_mem[vm_q.env_pos];
        end
        if (item_acc && i_item.opcode == wvm_pkg::OP_VIB) begin
            vib_mem[i_item.address] <= i_item.gain_value;
        end
        if (vib_step) begin
            r_vib_q <= vib_mem[r_vib_pos];
        end
    end

    // ---------------- stage 2: multiply ----------------
    assign s2_w    = r_s2_zero ? '0 : r_wave_q;
    assign s2_g    = r_s2_held ? r_vib_q : r_env_q;
    assign s2_prod = PW'(s2_w) * PW'($signed({1'b0, s2_g}));

    // ---------------- stage 3: Q2.14 truncate toward zero, accumulate ----------------
    assign s3_bias = r_prod + (r_prod[PW-1] ? 33'sd16383 : 33'sd0);
    assign s3_q    = s3_bias[PW-1:14];

    always_comb begin
        s3_term = ACC_W'(s3_q);
        if (r_s3_held) begin
            priority if (!r_vib_en) begin
                s3_term = ACC_W'(r_s3_w);
            end else if (s3_q > 19'(wvm_pkg::HELD_MAX)) begin
                s3_term = ACC_W'(wvm_pkg::HELD_MAX);
            end else if (s3_q < 19'(wvm_pkg::HELD_MIN)) begin
                s3_term = ACC_W'(wvm_pkg::HELD_MIN);
            end else begin
                s3_term = ACC_W'(s3_q);
            end
        end
    end

    assign acc_sum = r_acc + s3_term;

    always_comb begin
        priority if (r_acc > ACC_W'(wvm_pkg::SAMPLE_MAX)) begin
            sat_sample = 21'(wvm_pkg::SAMPLE_MAX);
        end else if (r_acc < ACC_W'(wvm_pkg::SAMPLE_MIN)) begin
            sat_sample = 21'(wvm_pkg::SAMPLE_MIN);
        end else begin
            sat_sample = r_acc[wvm_pkg::SAMPLE_W-1:0];
        end
    end

    assign o_result.valid  = r_out_valid;
    assign o_result.sample = r_out_sample;

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= wvm_pkg::ST_IDLE;
            r_vib_en     <= 1'b0;
            r_decay_step <= 16'd1;
            r_cnt        <= '0;
            r_s1_vld     <= 1'b0;
            r_s2_vld     <= 1'b0;
            r_s3_vld     <= 1'b0;
            r_vib_pos    <= '0;
            r_vib_tick   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                if (i_cfg.index == wvm_pkg::REG_VIB_EN) begin
                    r_vib_en <= i_cfg.data[0];
                end else if (i_cfg.index == wvm_pkg::REG_DECAY_STEP) begin
                    r_decay_step <= i_cfg.data;
                end
            end
            if (item_acc) begin
                r_cnt <= '0;
            end else if (issue) begin
                r_cnt <= r_cnt + CW'(1);
            end
            r_s1_vld <= issue;
            r_s2_vld <= s1_act;
            r_s3_vld <= r_s2_vld;
            if (vib_step) begin
                r_vib_pos  <= n_vib_pos;
                r_vib_tick <= n_vib_tick;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (item_acc) begin
            r_op      <= i_item.opcode;
            r_note    <= i_item.note;
            r_play    <= !i_item.pause && note_ok_in;
            r_note_ok <= note_ok_in;
            r_len     <= i_item.length_value;
            r_acc     <= '0;
        end else if (r_s3_vld) begin
            r_acc <= acc_sum;
        end
        r_s1_held  <= (r_cnt == '0);
        r_s1_voice <= slot_voice;
        r_s2_held  <= r_s1_held;
        r_s2_zero  <= !s1_phase_ok;
        r_s3_held  <= r_s2_held;
        r_s3_w     <= s2_w;
        r_prod     <= s2_prod;
        if (out_load) begin
            r_out_sample <= sat_sample;
        end
    end

    // ---------------- assertions ----------------
    a_pipe_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld || r_s2_vld || r_s3_vld) |-> (r_state == wvm_pkg::ST_RUN))
        else $error("voice pipe busy outside a tick");

    a_vib_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vib_tick < 4'(VIB_DIV)) && ({1'b0, r_vib_pos} < 10'(VIB_LEN)))
        else $error("vibrato position out of range");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wvm_pkg::ST_DONE && (!r_out_valid || o_result.ready))
        |=> (r_out_valid && r_state == wvm_pkg::ST_IDLE))
        else $error("finished tick did not load the output register");

    a_nontick_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item_acc && i_item.opcode != wvm_pkg::OP_TICK) |=> (r_state != wvm_pkg::ST_RUN))
        else $error("non-tick beat started a mix pass");

endmodule

`default_nettype wire

FILE: rtl/core/wvm_voice_mem.sv
// Per-voice state memory: one read and one write port, registered read,
// entry valid bits for reset, write-to-read forwarding. Depends on wvm_pkg.
`default_nettype none

module wvm_voice_mem #(
    parameter int VOICES = wvm_pkg::VOICES_DEF,
    parameter int VW     = 5
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_rd_en,
    input  wire logic [VW-1:0]   i_rd_addr,
    input  wire logic            i_wr_en,
    input  wire logic [VW-1:0]   i_wr_addr,
    input  wire wvm_pkg::t_voice i_wr_data,
    output wvm_pkg::t_voice      o_rd_data
);

    wvm_pkg::t_voice mem [VOICES];
    logic [VOICES-1:0] r_valid;
    wvm_pkg::t_voice   r_q;
    wvm_pkg::t_voice   r_fwd_data;
    logic              r_hit;
    logic              r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q        <= mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_hit   <= 1'b0;
            r_fwd   <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_hit <= r_valid[i_rd_addr];
                r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
            end
        end
    end

    // unwritten entries read as the reset state
    assign o_rd_data = r_fwd ? r_fwd_data : (r_hit ? r_q : '0);

endmodule

`default_nettype wire
